// ----- hw/rtl/battery_thermal_charge_controller_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the charge controller RTL.
// ----------------------------------------------------------------------------
`ifndef BATTERY_THERMAL_CHARGE_CONTROLLER_CORE_MACROS_SVH
`define BATTERY_THERMAL_CHARGE_CONTROLLER_CORE_MACROS_SVH

// Checked on every rising edge of aclk, ignored while reset is held.
`define BTCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define BTCC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- hw/rtl/btcc_pkg.sv -----
// ----------------------------------------------------------------------------
// btcc_pkg
// Types and constants shared by the charge controller modules.
// ----------------------------------------------------------------------------
package btcc_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_COLD_BOUND     = 3'd0;
    localparam logic [2:0] CFG_COOL_BOUND     = 3'd1;
    localparam logic [2:0] CFG_NORMAL_BOUND   = 3'd2;
    localparam logic [2:0] CFG_WARM_BOUND     = 3'd3;
    localparam logic [2:0] CFG_HOT_BOUND      = 3'd4;
    localparam logic [2:0] CFG_OVERHEAT_BOUND = 3'd5;
    localparam logic [2:0] CFG_VOLT_THRESH    = 3'd6;
    localparam logic [2:0] CFG_REDUCED_CUR    = 3'd7;

    // Configuration reset values
    localparam logic signed [11:0] COLD_BOUND_RST     = -12'sd101;
    localparam logic signed [11:0] COOL_BOUND_RST     = -12'sd50;
    localparam logic signed [11:0] NORMAL_BOUND_RST   = 12'sd430;
    localparam logic signed [11:0] WARM_BOUND_RST     = 12'sd450;
    localparam logic signed [11:0] HOT_BOUND_RST      = 12'sd520;
    localparam logic signed [11:0] OVERHEAT_BOUND_RST = 12'sd550;
    localparam logic [22:0]        VOLT_THRESH_RST    = 23'd4000000;
    localparam logic [11:0]        REDUCED_CUR_RST    = 12'd450;

    // Temperature zones, coldest first
    localparam logic [2:0] ZONE_COLD     = 3'd0;
    localparam logic [2:0] ZONE_COOL     = 3'd1;
    localparam logic [2:0] ZONE_NORMAL   = 3'd2;
    localparam logic [2:0] ZONE_WARM     = 3'd3;
    localparam logic [2:0] ZONE_HOT      = 3'd4;
    localparam logic [2:0] ZONE_HIGH     = 3'd5;
    localparam logic [2:0] ZONE_OVERHEAT = 3'd6;

    // Transition codes
    localparam logic [2:0] TRANS_NONE           = 3'd0;
    localparam logic [2:0] TRANS_NORMAL_STOP    = 3'd1;
    localparam logic [2:0] TRANS_NORMAL_REDUCED = 3'd2;
    localparam logic [2:0] TRANS_REDUCED_STOP   = 3'd3;
    localparam logic [2:0] TRANS_REDUCED_NORMAL = 3'd4;
    localparam logic [2:0] TRANS_STOP_NORMAL    = 3'd5;
    localparam logic [2:0] TRANS_STOP_REDUCED   = 3'd6;

    // Health codes
    localparam logic [1:0] HEALTH_GOOD     = 2'd0;
    localparam logic [1:0] HEALTH_OVERHEAT = 2'd1;
    localparam logic [1:0] HEALTH_COLD     = 2'd2;

    // Output charge mode codes
    localparam logic [1:0] MODE_CODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_CODE_REDUCED = 2'd1;
    localparam logic [1:0] MODE_CODE_STOP    = 2'd2;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'b001,
        MODE_REDUCED = 3'b010,
        MODE_STOP    = 3'b100
    } mode_t;

    typedef struct packed {
        logic [5:0][11:0] bound;       // two's complement, index = register index
        logic [22:0]      volt_thresh;
        logic [11:0]      reduced_cur;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  charge_mode;
        logic [2:0]  transition;
        logic        update_req;
        logic        disable_charge;
        logic [11:0] charge_current;
        logic [1:0]  health;
        logic        pseudo_indication;
    } result_t;

    function automatic logic [1:0] mode_code(input mode_t mode);
        logic [1:0] code;
        unique case (mode)
            MODE_NORMAL:  code = MODE_CODE_NORMAL;
            MODE_REDUCED: code = MODE_CODE_REDUCED;
            MODE_STOP:    code = MODE_CODE_STOP;
            default:      code = MODE_CODE_NORMAL;
        endcase
        return code;
    endfunction

endpackage

// ----- hw/rtl/btcc_cfg.sv -----
// ----------------------------------------------------------------------------
// btcc_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module btcc_cfg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [22:0]   cfg_wdata,
    output btcc_pkg::cfg_t cfg
);
    import btcc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bound[0]    <= COLD_BOUND_RST;
            cfg_reg.bound[1]    <= COOL_BOUND_RST;
            cfg_reg.bound[2]    <= NORMAL_BOUND_RST;
            cfg_reg.bound[3]    <= WARM_BOUND_RST;
            cfg_reg.bound[4]    <= HOT_BOUND_RST;
            cfg_reg.bound[5]    <= OVERHEAT_BOUND_RST;
            cfg_reg.volt_thresh <= VOLT_THRESH_RST;
            cfg_reg.reduced_cur <= REDUCED_CUR_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_COLD_BOUND:     cfg_reg.bound[0]    <= cfg_wdata[11:0];
                CFG_COOL_BOUND:     cfg_reg.bound[1]    <= cfg_wdata[11:0];
                CFG_NORMAL_BOUND:   cfg_reg.bound[2]    <= cfg_wdata[11:0];
                CFG_WARM_BOUND:     cfg_reg.bound[3]    <= cfg_wdata[11:0];
                CFG_HOT_BOUND:      cfg_reg.bound[4]    <= cfg_wdata[11:0];
                CFG_OVERHEAT_BOUND: cfg_reg.bound[5]    <= cfg_wdata[11:0];
                CFG_VOLT_THRESH:    cfg_reg.volt_thresh <= cfg_wdata;
                CFG_REDUCED_CUR:    cfg_reg.reduced_cur <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/btcc_zone.sv -----
// ----------------------------------------------------------------------------
// btcc_zone
// Sorts a temperature into one of seven zones against six bounds.
// ----------------------------------------------------------------------------
module btcc_zone (
    input  logic signed [11:0]  temperature,
    input  logic [5:0][11:0]    bound,
    output logic [2:0]          zone
);
    import btcc_pkg::*;

    logic [5:0] above;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            above[k] = temperature > $signed(bound[k]);
        end
    end

    // Top-down priority; with unordered bounds the first hit from the top wins
    always_comb begin
        if (above[5])      zone = ZONE_OVERHEAT;
        else if (above[4]) zone = ZONE_HIGH;
        else if (above[3]) zone = ZONE_HOT;
        else if (above[2]) zone = ZONE_WARM;
        else if (above[1]) zone = ZONE_NORMAL;
        else if (above[0]) zone = ZONE_COOL;
        else               zone = ZONE_COLD;
    end

endmodule

// ----- hw/rtl/btcc_ctrl.sv -----
// ----------------------------------------------------------------------------
// btcc_ctrl
// Charge mode state machine, current clamp and change tracking.
// ----------------------------------------------------------------------------
module btcc_ctrl #(
    parameter int DEFAULT_CURRENT = 1000
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic              charger_present,
    input  logic [2:0]        zone,
    input  logic [22:0]       voltage,
    input  logic [11:0]       thermal_limit,
    input  logic [11:0]       max_current,
    input  btcc_pkg::cfg_t    cfg,
    output btcc_pkg::result_t result
);
    import btcc_pkg::*;

    localparam logic [11:0] STOP_CURRENT = 12'(DEFAULT_CURRENT);

    logic        last_charger_reg;
    mode_t       mode_reg, mode_next;
    logic        pseudo_reg, pseudo_next;
    logic [11:0] last_current_reg, current_next;

    logic        attach;
    mode_t       mode_start;
    logic        extreme;
    logic [2:0]  trans;

    always_comb begin
        attach     = charger_present && !last_charger_reg;
        mode_start = attach ? MODE_NORMAL : mode_reg;
        extreme    = (zone == ZONE_COLD) || (zone == ZONE_OVERHEAT);

        mode_next   = mode_start;
        pseudo_next = pseudo_reg;
        trans       = TRANS_NONE;

        unique case (mode_start)
            MODE_NORMAL: begin
                if (extreme) begin
                    trans       = TRANS_NORMAL_STOP;
                    pseudo_next = 1'b0;
                    mode_next   = MODE_STOP;
                end else if (zone >= ZONE_HOT) begin
                    if (voltage >= cfg.volt_thresh) begin
                        trans     = TRANS_NORMAL_STOP;
                        mode_next = MODE_STOP;
                    end else begin
                        trans     = TRANS_NORMAL_REDUCED;
                        mode_next = MODE_REDUCED;
                    end
                    pseudo_next = 1'b1;
                end
            end
            MODE_REDUCED: begin
                if (extreme) begin
                    trans       = TRANS_REDUCED_STOP;
                    pseudo_next = 1'b0;
                    mode_next   = MODE_STOP;
                end else if (zone < ZONE_WARM) begin
                    trans       = TRANS_REDUCED_NORMAL;
                    pseudo_next = 1'b1;
                    mode_next   = MODE_NORMAL;
                end else if (voltage > cfg.volt_thresh) begin
                    trans       = TRANS_REDUCED_STOP;
                    pseudo_next = 1'b1;
                    mode_next   = MODE_STOP;
                end
            end
            MODE_STOP: begin
                if (extreme) begin
                    pseudo_next = 1'b0;
                end else if (zone == ZONE_NORMAL) begin
                    trans       = TRANS_STOP_NORMAL;
                    pseudo_next = 1'b1;
                    mode_next   = MODE_NORMAL;
                end else if (zone == ZONE_WARM || zone == ZONE_HOT) begin
                    if (voltage < cfg.volt_thresh) begin
                        trans     = TRANS_STOP_REDUCED;
                        mode_next = MODE_REDUCED;
                    end
                    pseudo_next = 1'b1;
                end
            end
            default: ;
        endcase

        unique case (mode_next)
            MODE_NORMAL:
                current_next = (thermal_limit <= max_current) ? thermal_limit : max_current;
            MODE_REDUCED:
                current_next = (thermal_limit <= cfg.reduced_cur) ? thermal_limit
                                                                  : cfg.reduced_cur;
            default:
                current_next = STOP_CURRENT;
        endcase

        result.charge_mode       = mode_code(mode_next);
        result.transition        = trans;
        result.update_req        = attach || (last_current_reg != current_next);
        result.disable_charge    = (mode_next == MODE_STOP);
        result.charge_current    = current_next;
        result.health            = (zone == ZONE_OVERHEAT) ? HEALTH_OVERHEAT :
                                   ((zone == ZONE_COLD) ? HEALTH_COLD : HEALTH_GOOD);
        result.pseudo_indication = pseudo_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_charger_reg <= 1'b0;
            mode_reg         <= MODE_NORMAL;
            pseudo_reg       <= 1'b0;
            last_current_reg <= 12'd0;
        end else if (advance) begin
            last_charger_reg <= charger_present;
            mode_reg         <= mode_next;
            pseudo_reg       <= pseudo_next;
            last_current_reg <= current_next;
        end
    end

endmodule

// ----- hw/rtl/battery_thermal_charge_controller_core.sv -----
// ----------------------------------------------------------------------------
// battery_thermal_charge_controller_core
// Battery thermal charge controller: zones, charge mode FSM, current clamp.
// Pipeline: a sample passes through the input register and then the result
//   register before its result transaction is offered on m_tdata.
// Throughput: 1 sample per cycle while m_tready stays high; the mode state
//   updates in the single compute stage between the two registers.
// Reset: synchronous active-low aresetn clears both stage valids, the controller
//   state and restores all configuration registers to their defaults.
// ----------------------------------------------------------------------------
module battery_thermal_charge_controller_core #(
    parameter int DEFAULT_CURRENT = 1000
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [22:0] cfg_wdata,

    // Sample input
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] charger_present, [12:1] temperature, [35:13] voltage,
    // [47:36] thermal_limit, [59:48] max_current, [63:60] unused
    input  logic [63:0] s_tdata,

    // Result output
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] charge_mode, [4:2] transition, [5] update_req,
    // [6] disable_charge, [18:7] charge_current, [20:19] health,
    // [21] pseudo_indication, [23:22] zero
    output logic [23:0] m_tdata
);
    import btcc_pkg::*;

    `include "battery_thermal_charge_controller_core_macros.svh"

    localparam logic [11:0] STOP_CURRENT = 12'(DEFAULT_CURRENT);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    cfg_t cfg;

    btcc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // ------------------------------------------------------------------
    // Stage handshake. The result register loads when empty or being
    // drained; the input register then hands its sample forward, and can
    // take a new transaction in the same cycle.
    // ------------------------------------------------------------------
    logic        in_valid_reg, in_valid_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_open;
    logic        advance;
    logic        s_fire;

    assign out_open = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_open;
    assign s_tready = !in_valid_reg || out_open;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        if (s_fire)       in_valid_next = 1'b1;
        else if (advance) in_valid_next = 1'b0;
        else              in_valid_next = in_valid_reg;

        if (advance)       out_valid_next = 1'b1;
        else if (m_tready) out_valid_next = 1'b0;
        else               out_valid_next = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Input register (payload only, no reset)
    // ------------------------------------------------------------------
    logic               charger_reg;
    logic signed [11:0] temperature_reg;
    logic [22:0]        voltage_reg;
    logic [11:0]        thermal_limit_reg;
    logic [11:0]        max_current_reg;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            charger_reg       <= s_tdata[0];
            temperature_reg   <= s_tdata[12:1];
            voltage_reg       <= s_tdata[35:13];
            thermal_limit_reg <= s_tdata[47:36];
            max_current_reg   <= s_tdata[59:48];
        end
    end

    // ------------------------------------------------------------------
    // Compute stage: zone sort feeding the mode FSM. FSM state commits
    // only when the sample moves into the result register.
    // ------------------------------------------------------------------
    logic [2:0] zone;
    result_t    result;

    btcc_zone u_zone (
        .temperature (temperature_reg),
        .bound       (cfg.bound),
        .zone        (zone)
    );

    btcc_ctrl #(
        .DEFAULT_CURRENT (DEFAULT_CURRENT)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .charger_present (charger_reg),
        .zone            (zone),
        .voltage         (voltage_reg),
        .thermal_limit   (thermal_limit_reg),
        .max_current     (max_current_reg),
        .cfg             (cfg),
        .result          (result)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    result_t result_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       result_reg.pseudo_indication,
                       result_reg.health,
                       result_reg.charge_current,
                       result_reg.disable_charge,
                       result_reg.update_req,
                       result_reg.transition,
                       result_reg.charge_mode};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BTCC_ASSERT_RST(a_reset_empties, !aresetn |=> !in_valid_reg && !out_valid_reg, "stage valid after reset")
    `BTCC_ASSERT(a_ready_when_empty, !out_valid_reg |-> s_tready, "input stalled with empty result stage")
    `BTCC_ASSERT(a_disable_matches_mode, out_valid_reg |-> result_reg.disable_charge == (result_reg.charge_mode == MODE_CODE_STOP), "disable_charge disagrees with mode")
    `BTCC_ASSERT(a_extreme_stops, out_valid_reg && result_reg.health != HEALTH_GOOD |-> result_reg.charge_mode == MODE_CODE_STOP && !result_reg.pseudo_indication, "extreme temperature without stop")
    `BTCC_ASSERT(a_stop_current, out_valid_reg && result_reg.disable_charge |-> result_reg.charge_current == STOP_CURRENT, "stopped mode current not default")

endmodule
